### design/multi_servo_pulse_sequencer_defines.svh
// Assertion helpers for the top-level RTL file.
`ifndef MULTI_SERVO_PULSE_SEQUENCER_DEFINES_SVH
`define MULTI_SERVO_PULSE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/msps_pkg.sv
package msps_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PINS_W     = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PULSE    = 2'd0,
    CFG_FRAME_BUDGET = 2'd1,
    CFG_OVERHEAD     = 2'd2
  } cfg_reg_t;

  // Register reset values
  localparam logic [15:0] MIN_PULSE_RST    = 16'd1000;
  localparam logic [15:0] FRAME_BUDGET_RST = 16'd25500;
  localparam logic [3:0]  OVERHEAD_RST     = 4'd3;

  // Angles loaded at reset, indexed by channel
  localparam logic [7:0] START_ANGLES [8] = '{
    8'd90, 8'd90, 8'd0, 8'd90, 8'd90, 8'd10, 8'd0, 8'd0
  };

  // 65/3 ticks per degree; divide by 3 as multiply by reciprocal
  localparam logic [14:0] TICKS_NUM   = 15'd65;
  localparam logic [31:0] DIV3_RECIP  = 32'd43691;
  localparam int          DIV3_SHIFT  = 17;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_WRITE = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [2:0]  channel;
    logic [7:0]  angle;
  } in_item_t;

  typedef struct packed {
    logic [PINS_W-1:0] servo_pins;
    logic              frame_end;
  } out_item_t;

  // Shadow angle write request into the angle bank
  typedef struct packed {
    logic       wr_en;
    logic [2:0] wr_channel;
    logic [7:0] wr_angle;
  } angle_wr_t;

  // Pulse width in ticks: min_pulse + floor(angle*65/3), saturated to 16 bits
  function automatic logic [15:0] pulse_width(input logic [15:0] min_pulse,
                                              input logic [7:0]  angle);
    logic [14:0] scaled;
    logic [31:0] prod;
    logic [12:0] quot;
    logic [16:0] total;
    scaled = 15'(angle) * TICKS_NUM;
    prod   = 32'(scaled) * DIV3_RECIP;
    quot   = 13'(prod >> DIV3_SHIFT);
    total  = 17'(min_pulse) + 17'(quot);
    return total[16] ? 16'hFFFF : total[15:0];
  endfunction

endpackage

### design/msps_angle_bank.sv
module msps_angle_bank #(
  parameter int CHANNELS = 6,
  parameter int SLOT_W   = $clog2(CHANNELS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  msps_pkg::angle_wr_t wr,
  input  logic                load,
  input  logic                frame_start,
  input  logic [SLOT_W-1:0]   slot,
  output logic [7:0]          angle
);
  import msps_pkg::*;

  logic [7:0] shadow [CHANNELS];
  logic [7:0] active [CHANNELS];

  // Shadow writes and frame-start copy into the active set
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        shadow[i] <= START_ANGLES[i];
        active[i] <= START_ANGLES[i];
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (wr.wr_en && wr.wr_channel == 3'(i)) shadow[i] <= wr.wr_angle;
        if (load) active[i] <= shadow[i];
      end
    end
  end

  // Angle of the current slot; at frame start the copy is not yet visible
  always_comb begin
    angle = '0;
    if (frame_start) begin
      angle = shadow[0];
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (slot == SLOT_W'(i)) angle = active[i];
      end
    end
  end

endmodule

### design/msps_slot_timer.sv
module msps_slot_timer #(
  parameter int CHANNELS = 6,
  parameter int SLOT_W   = $clog2(CHANNELS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [15:0]         min_pulse,
  input  logic [15:0]         frame_budget,
  input  logic [3:0]          overhead,
  input  logic [7:0]          angle,
  output logic [SLOT_W-1:0]   slot,
  output logic                frame_start,
  output logic                load,
  output msps_pkg::out_item_t result
);
  import msps_pkg::*;

  localparam logic [SLOT_W-1:0] GAP_SLOT = SLOT_W'(CHANNELS);

  logic [15:0] tick_count, tick_count_next;
  logic [16:0] used_sum, used_sum_next;
  logic [SLOT_W-1:0] slot_next;

  logic        in_gap;
  logic [15:0] width;
  logic [11:0] ovh_term;
  logic [16:0] sum_base;
  logic [17:0] sum_raw;
  logic [15:0] gap;
  logic        slot_done;

  assign in_gap      = (slot == GAP_SLOT);
  assign frame_start = (slot == '0) && (tick_count == '0);
  assign load        = step && frame_start;

  // Width, frame budget accounting and gap length for the current tick
  always_comb begin
    width    = pulse_width(min_pulse, angle);
    ovh_term = 12'(overhead) * 12'(angle);
    sum_base = frame_start ? '0 : used_sum;
    sum_raw  = 18'(sum_base) + 18'(width) + 18'(ovh_term);
    gap      = (used_sum >= 17'(frame_budget)) ? '0 : 16'(17'(frame_budget) - used_sum);
    slot_done = in_gap ? (tick_count >= gap) : (tick_count >= width);
  end

  // Slot sequencing
  always_comb begin
    slot_next       = slot;
    tick_count_next = tick_count;
    used_sum_next   = used_sum;
    if (step) begin
      if (!in_gap && tick_count == '0) begin
        used_sum_next = sum_raw[17] ? '1 : sum_raw[16:0];
      end
      if (slot_done) begin
        tick_count_next = '0;
        slot_next       = in_gap ? '0 : slot + 1'b1;
      end else begin
        tick_count_next = tick_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      tick_count <= '0;
      used_sum   <= '0;
    end else begin
      slot       <= slot_next;
      tick_count <= tick_count_next;
      used_sum   <= used_sum_next;
    end
  end

  // Pin levels of the current slot; frame end on the last gap tick
  always_comb begin
    result.servo_pins = '0;
    for (int i = 0; i < PINS_W; i++) begin
      if (i < CHANNELS) result.servo_pins[i] = (slot == SLOT_W'(i));
    end
    result.frame_end = step && in_gap && slot_done;
  end

endmodule

### design/multi_servo_pulse_sequencer.sv
// Six-channel (CHANNELS) servo pulse sequencer. Each input transfer is either
// one timer tick or a shadow angle write; every input transfer yields exactly
// one output transfer with the pin levels and a frame-end flag. One item is
// taken per clock while the output does not stall. An item is held in the
// input register while the single pass of pulse width and frame accounting
// runs, and its result is then captured in the result register and offered
// on the output. Shadow angles reach the pins at the next frame start.
// Configuration writes apply immediately and should be issued only while no
// transfers are in flight.
module multi_servo_pulse_sequencer #(
  parameter int CHANNELS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  msps_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output msps_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [msps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import msps_pkg::*;
  `include "multi_servo_pulse_sequencer_defines.svh"

  localparam int SLOT_W = $clog2(CHANNELS + 1);

  logic [15:0] min_pulse;
  logic [15:0] frame_budget;
  logic [3:0]  overhead;

  in_item_t  item_q;
  logic      item_valid;
  logic      advance;
  logic      process;
  logic      step;
  angle_wr_t wr;
  logic [7:0] angle;
  logic [SLOT_W-1:0] slot;
  logic      frame_start;
  logic      load;
  out_item_t result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse    <= MIN_PULSE_RST;
      frame_budget <= FRAME_BUDGET_RST;
      overhead     <= OVERHEAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MIN_PULSE:    min_pulse    <= cfg_data;
        CFG_FRAME_BUDGET: frame_budget <= cfg_data;
        CFG_OVERHEAD:     overhead     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Input register and result register flow control
  assign advance  = !out_valid || out_ready;
  assign in_ready = !item_valid || advance;
  assign process  = item_valid && advance;
  assign step     = process && (item_q.kind == KIND_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_q <= in_data;
  end

  assign wr.wr_en      = process && (item_q.kind == KIND_WRITE);
  assign wr.wr_channel = item_q.channel;
  assign wr.wr_angle   = item_q.angle;

  msps_angle_bank #(
    .CHANNELS (CHANNELS),
    .SLOT_W   (SLOT_W)
  ) u_bank (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .load        (load),
    .frame_start (frame_start),
    .slot        (slot),
    .angle       (angle)
  );

  msps_slot_timer #(
    .CHANNELS (CHANNELS),
    .SLOT_W   (SLOT_W)
  ) u_timer (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .min_pulse    (min_pulse),
    .frame_budget (frame_budget),
    .overhead     (overhead),
    .angle        (angle),
    .slot         (slot),
    .frame_start  (frame_start),
    .load         (load),
    .result       (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) out_data <= result;
  end

  // Checks
  `MSPS_ASSERT_NOW(a_pins_onehot, out_valid, $onehot0(out_data.servo_pins), "pins not one-hot")
  `MSPS_ASSERT_NOW(a_fend_in_gap, out_valid && out_data.frame_end, out_data.servo_pins == '0, "frame end with a pin high")
  `MSPS_ASSERT_NOW(a_slot_range, 1'b1, slot <= SLOT_W'(CHANNELS), "slot index past gap")

endmodule
